/* rtl/core/bzf_pkg.sv */
// Shared types, register codes and constants of the Bezier flattener.
`default_nettype none

package bzf_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int MAP_FRAC    = 14;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 3'd0,
    REG_CENTER_X = 3'd1,
    REG_CENTER_Y = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        [CFG_W-1:0] scale;
    logic signed [CFG_W-1:0] center_x;
    logic signed [CFG_W-1:0] center_y;
    logic signed [CFG_W-1:0] offset_x;
    logic signed [CFG_W-1:0] offset_y;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    scale:    16'd4342,
    center_x: 16'sd11264,
    center_y: 16'sd9114,
    offset_x: 16'sd0,
    offset_y: 16'sd0
  };

  // Bernstein weight j of sample k, scaled by s^3
  function automatic longint bern_weight(input int s, input int k, input int j);
    longint r;
    longint kk;
    longint res;
    r  = longint'(s - k);
    kk = longint'(k);
    case (j)
      0:       res = r * r * r;
      1:       res = 3 * kk * r * r;
      2:       res = 3 * kk * kk * r;
      3:       res = kk * kk * kk;
      default: res = 0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bzf_if.sv */
// Input and result channel interfaces of the Bezier flattener.
`default_nettype none

interface bzf_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] handle_a_x;
  logic signed [COORD_WIDTH-1:0] handle_a_y;
  logic signed [COORD_WIDTH-1:0] handle_b_x;
  logic signed [COORD_WIDTH-1:0] handle_b_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic                          final_segment;

  modport source (
    output valid, start_x, start_y, handle_a_x, handle_a_y,
           handle_b_x, handle_b_y, end_x, end_y, final_segment,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, handle_a_x, handle_a_y,
           handle_b_x, handle_b_y, end_x, end_y, final_segment,
    output ready
  );
endinterface

interface bzf_out_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          run_last;

  modport source (output valid, point_x, point_y, run_last, input ready);
  modport sink   (input valid, point_x, point_y, run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/bzf_fifo.sv */
// Short segment queue between the mapping front and the sampling back.
`default_nettype none

module bzf_fifo
  import bzf_pkg::*;
#(
  parameter int WIDTH = 129,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNTW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_ready && pop_valid;
  assign pop_data   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH - 1)) ? '0 : AW'(wr_r + 1'b1);
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH - 1)) ? '0 : AW'(rd_r + 1'b1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = CNTW'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = CNTW'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bzf_front.sv */
// Front end: accepts segments and maps the control points into the output frame.
`default_nettype none

module bzf_front
  import bzf_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  bzf_in_if.sink                      in_chan,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output logic [8*COORD_WIDTH:0]      push_data
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = ((CW > CFG_W) ? CW : CFG_W) + 1;
  localparam int PW = DW + CFG_W + 1;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (MAP_FRAC - 1);
  localparam logic signed [PW-1:0] MAXV = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [PW-1:0] MINV = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic signed [CW-1:0] pt_in    [8];
  logic signed [DW-1:0] pt_ext   [8];
  logic signed [DW-1:0] diff_nxt [8];
  logic signed [DW-1:0] cx_ext, cy_ext;
  logic signed [CFG_W:0] sc;

  logic                 v1_r, v2_r, v3_r;
  logic                 fin1_r, fin2_r, fin3_r;
  logic signed [DW-1:0] d1_r  [8];
  logic signed [PW-1:0] p2_r  [8];
  logic signed [PW-1:0] p2_nxt [8];
  logic signed [CW-1:0] m3_r  [8];
  logic signed [CW-1:0] m3_nxt [8];
  logic signed [PW-1:0] rnd   [8];
  logic signed [PW-1:0] sh    [8];
  logic                 fen, acc;

  assign pt_in[0] = in_chan.start_x;
  assign pt_in[1] = in_chan.start_y;
  assign pt_in[2] = in_chan.handle_a_x;
  assign pt_in[3] = in_chan.handle_a_y;
  assign pt_in[4] = in_chan.handle_b_x;
  assign pt_in[5] = in_chan.handle_b_y;
  assign pt_in[6] = in_chan.end_x;
  assign pt_in[7] = in_chan.end_y;

  assign cx_ext = {{(DW-CFG_W){cfg.center_x[CFG_W-1]}}, cfg.center_x};
  assign cy_ext = {{(DW-CFG_W){cfg.center_y[CFG_W-1]}}, cfg.center_y};
  assign sc     = $signed({1'b0, cfg.scale});

  // whole front moves together; stalls only when the queue is full
  assign fen           = !v3_r || push_ready;
  assign in_chan.ready = fen;
  assign acc           = in_chan.valid && fen;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pt_ext[i] = {{(DW-CW){pt_in[i][CW-1]}}, pt_in[i]};
      // y axis is flipped: center minus point
      if ((i % 2) == 0) begin
        diff_nxt[i] = pt_ext[i] - cx_ext;
      end else begin
        diff_nxt[i] = cy_ext - pt_ext[i];
      end
      p2_nxt[i] = PW'(sc) * PW'(d1_r[i]);
      rnd[i]    = p2_r[i] + HALF;
      sh[i]     = rnd[i] >>> MAP_FRAC;
      if (sh[i] > MAXV) begin
        m3_nxt[i] = MAXV[CW-1:0];
      end else if (sh[i] < MINV) begin
        m3_nxt[i] = MINV[CW-1:0];
      end else begin
        m3_nxt[i] = sh[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (fen) begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fen) begin
      fin1_r <= in_chan.final_segment;
      fin2_r <= fin1_r;
      fin3_r <= fin2_r;
      for (int i = 0; i < 8; i++) begin
        d1_r[i] <= diff_nxt[i];
        p2_r[i] <= p2_nxt[i];
        m3_r[i] <= m3_nxt[i];
      end
    end
  end

  assign push_valid = v3_r;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      push_data[i*CW +: CW] = m3_r[i];
    end
    push_data[8*CW] = fin3_r;
  end

endmodule

`default_nettype wire

/* rtl/core/bzf_back.sv */
// Back end: evaluates the Bernstein cubic, one sample per cycle unless stalled.
`default_nettype none

module bzf_back
  import bzf_pkg::*;
#(
  parameter int SAMPLES     = 25,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfg_t                   cfg,
  input  wire logic                   seg_valid,
  output logic                        seg_pop,
  input  wire logic [8*COORD_WIDTH:0] seg_data,
  bzf_out_if.source                   out_chan
);

  localparam int CW = COORD_WIDTH;
  localparam int S3 = SAMPLES * SAMPLES * SAMPLES;
  localparam int WW = $clog2(S3 + 1);
  localparam int KW = $clog2(SAMPLES + 1);
  localparam int MW = WW + 1 + CW;
  localparam int SW = MW + 2;
  localparam int NW = WW + CW;
  localparam int QW = CW;
  localparam int OW = ((CW > CFG_W) ? CW : CFG_W) + 1;
  // reciprocal of S^3 scaled by 2^LSH; exact for every dividend below S^3 * 2^QW
  localparam int LSH = 2 * WW + QW;
  localparam int RW  = WW + QW + 2;
  localparam int RL  = RW / 2;
  localparam int RH  = RW - RL;
  localparam int PLW = NW + RL;
  localparam int PHW = NW + RH;
  localparam int PSW = NW + RW;

  localparam logic [KW-1:0] K_LAST_OPEN = KW'(SAMPLES - 1);
  localparam logic [KW-1:0] K_CLOSE     = KW'(SAMPLES);
  // rounding half plus an offset that keeps the dividend non-negative
  localparam logic signed [SW-1:0] BIAS = SW'(S3 / 2) + (SW'(S3) <<< (CW - 1));
  localparam logic [LSH:0]  POW_L    = {1'b1, {LSH{1'b0}}};
  localparam logic [LSH:0]  RECIP_W  = (POW_L + (LSH + 1)'(S3 - 1)) / (LSH + 1)'(S3);
  localparam logic [RW-1:0] RECIP    = RECIP_W[RW-1:0];
  localparam logic [RL-1:0] RECIP_LO = RECIP[RL-1:0];
  localparam logic [RH-1:0] RECIP_HI = RECIP[RW-1:RL];
  localparam logic signed [OW-1:0] OMAX = {{(OW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [OW-1:0] OMIN = {{(OW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  logic [WW-1:0] wtab [4][SAMPLES+1];

  for (genvar g = 0; g <= SAMPLES; g++) begin : g_wrow
    for (genvar j = 0; j < 4; j++) begin : g_wcol
      assign wtab[j][g] = WW'(bern_weight(SAMPLES, g, j));
    end
  end

  logic en;

  // sequencer
  logic              act_r, act_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [8*CW:0]     seg_r;
  logic              iss_last, take;

  // evaluation stages
  logic                 a_v_r, a_last_r;
  logic [WW-1:0]        a_w_r [4];
  logic signed [CW-1:0] a_p_r [8];
  logic                 b_v_r, b_last_r;
  logic signed [MW-1:0] b_prod_r [8];
  logic                 c_v_r, c_last_r;
  logic signed [SW-1:0] c01_r [2];
  logic signed [SW-1:0] c23_r [2];
  logic signed [SW-1:0] num   [2];

  // division stages: dividend, partial products, quotient
  logic                 d_v_r, d_last_r;
  logic [NW-1:0]        d_num_r [2];
  logic                 e_v_r, e_last_r;
  logic [PLW-1:0]       e_lo_r [2];
  logic [PHW-1:0]       e_hi_r [2];
  logic [PSW-1:0]       prod   [2];
  logic                 f_v_r, f_last_r;
  logic [QW-1:0]        f_q_r [2];

  logic signed [CW-1:0] q     [2];
  logic signed [OW-1:0] osum  [2];
  logic signed [CW-1:0] osat  [2];
  logic signed [OW-1:0] off_ext [2];

  logic                 out_v_r, out_last_r;
  logic signed [CW-1:0] out_x_r, out_y_r;

  assign en = !out_v_r || out_chan.ready;

  always_comb begin
    iss_last = act_r && (k_r == (seg_r[8*CW] ? K_CLOSE : K_LAST_OPEN));
    take     = !act_r || iss_last;
    seg_pop  = en && take && seg_valid;
    act_nxt  = act_r;
    k_nxt    = k_r;
    if (en) begin
      if (take) begin
        act_nxt = seg_valid;
        k_nxt   = '0;
      end else begin
        k_nxt = KW'(k_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      k_r   <= '0;
    end else begin
      act_r <= act_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_pop) begin
      seg_r <= seg_data;
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      num[a]  = c01_r[a] + c23_r[a];
      prod[a] = {e_hi_r[a], {RL{1'b0}}} + PSW'(e_lo_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= act_r;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_last_r <= iss_last;
      b_last_r <= a_last_r;
      c_last_r <= b_last_r;
      d_last_r <= c_last_r;
      e_last_r <= d_last_r;
      f_last_r <= e_last_r;
      for (int j = 0; j < 4; j++) begin
        a_w_r[j] <= wtab[j][k_r];
      end
      for (int i = 0; i < 8; i++) begin
        a_p_r[i]    <= seg_r[i*CW +: CW];
        b_prod_r[i] <= MW'($signed({1'b0, a_w_r[i >> 1]})) * MW'(a_p_r[i]);
      end
      for (int a = 0; a < 2; a++) begin
        c01_r[a]   <= SW'(b_prod_r[a]) + SW'(b_prod_r[a + 2]);
        c23_r[a]   <= SW'(b_prod_r[a + 4]) + SW'(b_prod_r[a + 6]) + BIAS;
        d_num_r[a] <= num[a][NW-1:0];
        // floor division by S^3 as a reciprocal multiply, split in two halves
        e_lo_r[a]  <= PLW'(d_num_r[a]) * PLW'(RECIP_LO);
        e_hi_r[a]  <= PHW'(d_num_r[a]) * PHW'(RECIP_HI);
        f_q_r[a]   <= prod[a][LSH+QW-1:LSH];
      end
    end
  end

  assign off_ext[0] = {{(OW-CFG_W){cfg.offset_x[CFG_W-1]}}, cfg.offset_x};
  assign off_ext[1] = {{(OW-CFG_W){cfg.offset_y[CFG_W-1]}}, cfg.offset_y};

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // remove the bias of half the coordinate range
      q[a]    = {~f_q_r[a][QW-1], f_q_r[a][QW-2:0]};
      osum[a] = {{(OW-CW){q[a][CW-1]}}, q[a]} + off_ext[a];
      if (osum[a] > OMAX) begin
        osat[a] = OMAX[CW-1:0];
      end else if (osum[a] < OMIN) begin
        osat[a] = OMIN[CW-1:0];
      end else begin
        osat[a] = osum[a][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x_r    <= osat[0];
      out_y_r    <= osat[1];
      out_last_r <= f_last_r;
    end
  end

  assign out_chan.valid    = out_v_r;
  assign out_chan.point_x  = out_x_r;
  assign out_chan.point_y  = out_y_r;
  assign out_chan.run_last = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/cubic_bezier_flattener.sv */
// Top level of the cubic Bezier flattener. Each accepted word is one segment
// (four control points); the front maps the points into the output frame through its
// difference, product and rounding registers and parks them in a four-deep queue, and
// the back issues one curve sample per clock, unless the output stalls, into an evaluation
// pipeline, so a segment yields SAMPLES samples, or SAMPLES+1 when final_segment adds the
// closing endpoint, and result words stream out at one per cycle with no gaps between
// segments while the output is taken. The sample sequencer sets that rate. The first
// result of a segment passes the front, the queue, the sequencer, the weighting pipeline
// and the reciprocal-multiply division by SAMPLES^3 before it reaches the output register.
// Configuration registers take effect on the next accepted segment and should be
// written with the block idle.
`default_nettype none

module cubic_bezier_flattener
  import bzf_pkg::*;
#(
  parameter int SAMPLES     = 25,
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  bzf_in_if.sink                    in_chan,
  bzf_out_if.source                 out_chan
);

  localparam int EW = 8 * COORD_WIDTH + 1;

  cfg_t          cfg_r, cfg_nxt;
  logic          push_valid, push_ready;
  logic [EW-1:0] push_data;
  logic          seg_valid, seg_pop;
  logic [EW-1:0] seg_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:    cfg_nxt.scale    = cfg_wdata;
        REG_CENTER_X: cfg_nxt.center_x = $signed(cfg_wdata);
        REG_CENTER_Y: cfg_nxt.center_y = $signed(cfg_wdata);
        REG_OFFSET_X: cfg_nxt.offset_x = $signed(cfg_wdata);
        REG_OFFSET_Y: cfg_nxt.offset_y = $signed(cfg_wdata);
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bzf_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bzf_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (seg_valid),
    .pop_ready  (seg_pop),
    .pop_data   (seg_data)
  );

  bzf_back #(
    .SAMPLES     (SAMPLES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .seg_valid (seg_valid),
    .seg_pop   (seg_pop),
    .seg_data  (seg_data),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

/* rtl/core/bzf_checker.sv */
// Port-level checks of the Bezier flattener and their binding to the top level.
`default_nettype none

module bzf_checker #(
  parameter int COORD_WIDTH = 16
) (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [COORD_WIDTH-1:0] point_x,
  input wire logic [COORD_WIDTH-1:0] point_y,
  input wire logic                   run_last
);

  logic [7:0] open_r, open_nxt;
  logic       in_acc, out_end;

  assign in_acc  = in_valid && in_ready;
  assign out_end = out_valid && out_ready && run_last;

  // segments accepted whose last point has not been taken yet
  always_comb begin
    open_nxt = open_r;
    if (in_acc && !out_end) begin
      open_nxt = 8'(open_r + 1'b1);
    end else if (!in_acc && out_end) begin
      open_nxt = 8'(open_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(point_x) && $stable(point_y) && $stable(run_last))
    else $error("stalled result word changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 8'd0)
    else $error("result word with no open segment");

endmodule

bind cubic_bezier_flattener bzf_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_bzf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .point_x   (out_chan.point_x),
  .point_y   (out_chan.point_y),
  .run_last  (out_chan.run_last)
);

`default_nettype wire
